[src/stk_pkg.sv]
// Shared types, constants and helper functions of the script tokenizer.
// Used by the front scanner, the token queue, the token drainer and the top level.
package stk_pkg;

   localparam int MAX_SOURCE_BYTES_DEFAULT = 65536;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [5:0] K_SLASH    = 6'd11;
   localparam logic [5:0] K_DOT      = 6'd5;
   localparam logic [5:0] K_IDENT    = 6'd21;
   localparam logic [5:0] K_STRING   = 6'd22;
   localparam logic [5:0] K_NUMBER   = 6'd23;
   localparam logic [5:0] K_KEYWORD0 = 6'd24;
   localparam logic [5:0] K_ERROR    = 6'd41;
   localparam logic [5:0] K_END      = 6'd42;

   localparam logic [1:0] E_NONE         = 2'd0;
   localparam logic [1:0] E_UNTERMINATED = 2'd1;
   localparam logic [1:0] E_UNEXPECTED   = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam int NUM_KEYWORDS = 17;

   // Keyword spellings, padded with zero bytes.
   localparam logic [7:0] KW_CHARS [NUM_KEYWORDS][8] = '{
      '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00},
      '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "i", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"s", "u", "p", "e", "r", 8'h00, 8'h00, 8'h00},
      '{"t", "h", "i", "s", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
      3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef enum logic [2:0] {
      M_IDLE, M_WORD, M_INT, M_INT_DOT, M_FRAC, M_STRING, M_COMMENT, M_OPERATOR
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [1:0]  err;
   } tok_type;

   typedef struct packed {
      logic [1:0]        count;
      tok_type [2:0]     toks;
   } bundle_type;

   function automatic tok_type mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                      input logic [15:0] length, input logic [15:0] line,
                                      input logic [1:0] err);
      tok_type t;
      t.kind = kind;
      t.start = start;
      t.length = length;
      t.line = line;
      t.err = err;
      return t;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] cap);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, cap}) ? cap : s[15:0];
   endfunction

   // Keywords whose character at position pos equals c.
   function automatic logic [NUM_KEYWORDS-1:0] keep_mask(input logic [2:0] pos,
                                                        input logic [7:0] c);
      logic [NUM_KEYWORDS-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         m[i] = (pos < 3'd6) && (KW_CHARS[i][pos] == c);
      end
      return m;
   endfunction

   // First surviving keyword of matching length, else identifier.
   function automatic logic [5:0] word_kind(input logic [NUM_KEYWORDS-1:0] cand,
                                           input logic [2:0] wlen);
      logic [5:0] k;
      k = K_IDENT;
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
         if (cand[i] && KW_LEN[i] == wlen) begin
            k = K_KEYWORD0 + 6'(i);
         end
      end
      return k;
   endfunction

   // Bit 6 set when c is a one-character token.
   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         "(": r = {1'b1, 6'd0};
         ")": r = {1'b1, 6'd1};
         "{": r = {1'b1, 6'd2};
         "}": r = {1'b1, 6'd3};
         ",": r = {1'b1, 6'd4};
         ".": r = {1'b1, 6'd5};
         ";": r = {1'b1, 6'd6};
         ":": r = {1'b1, 6'd7};
         "?": r = {1'b1, 6'd8};
         "-": r = {1'b1, 6'd9};
         "+": r = {1'b1, 6'd10};
         "*": r = {1'b1, 6'd12};
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] operator_kind(input logic [7:0] c, input logic doubled);
      logic [5:0] k;
      case (c)
         CH_BANG: k = doubled ? 6'd14 : 6'd13;
         CH_EQ:   k = doubled ? 6'd16 : 6'd15;
         CH_GT:   k = doubled ? 6'd18 : 6'd17;
         default: k = doubled ? 6'd20 : 6'd19;
      endcase
      return k;
   endfunction

endpackage

[src/stk_front.sv]
// Front scanner: takes one source byte per cycle while byte_valid is high and forms the tokens it completes.
// Depends on stk_pkg for token types, keyword table and character helpers.
module stk_front #(
   parameter int MAX_SOURCE_BYTES = stk_pkg::MAX_SOURCE_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          source_byte,
   output logic                bundle_push,
   output stk_pkg::bundle_type bundle
);

   localparam logic [15:0] OFFSET_CAP =
      (MAX_SOURCE_BYTES - 1 < 65535) ? 16'(MAX_SOURCE_BYTES - 1) : 16'hFFFF;

   stk_pkg::mode_type mode_ff, mode_in;
   logic [15:0] lstart_ff, lstart_in;
   logic [15:0] roff_ff, roff_in;
   logic [15:0] line_ff, line_in;
   logic [16:0] cand_ff, cand_in;
   logic [2:0]  wlen_ff, wlen_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] llen_ff, llen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stk_pkg::M_IDLE;
         lstart_ff <= '0;
         roff_ff   <= '0;
         line_ff   <= 16'd1;
         cand_ff   <= '0;
         wlen_ff   <= '0;
         held_ff   <= '0;
         llen_ff   <= '0;
      end else if (byte_valid) begin
         mode_ff   <= mode_in;
         lstart_ff <= lstart_in;
         roff_ff   <= roff_in;
         line_ff   <= line_in;
         cand_ff   <= cand_in;
         wlen_ff   <= wlen_in;
         held_ff   <= held_in;
         llen_ff   <= llen_in;
      end
   end

   always_comb begin
      logic [7:0] c;
      logic       rescan;
      logic [1:0] n;
      logic [6:0] sk;
      c = source_byte;
      rescan = 1'b0;
      n = 2'd0;
      sk = 7'd0;
      bundle = '0;
      mode_in = mode_ff;
      lstart_in = lstart_ff;
      roff_in = roff_ff;
      line_in = line_ff;
      cand_in = cand_ff;
      wlen_in = wlen_ff;
      held_in = held_ff;
      llen_in = llen_ff;

      case (mode_ff)
         stk_pkg::M_WORD: begin
            if (stk_pkg::is_letter(c) || stk_pkg::is_digit(c) || c == stk_pkg::CH_UNDER) begin
               llen_in = stk_pkg::sat_add(llen_ff, 16'd1, 16'hFFFF);
               cand_in = cand_ff & stk_pkg::keep_mask(wlen_ff, c);
               wlen_in = (wlen_ff < 3'd7) ? wlen_ff + 3'd1 : 3'd7;
            end else begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::word_kind(cand_ff, wlen_ff),
                                                lstart_ff, llen_ff, line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         stk_pkg::M_INT, stk_pkg::M_FRAC: begin
            if (stk_pkg::is_digit(c)) begin
               llen_in = stk_pkg::sat_add(llen_ff, 16'd1, 16'hFFFF);
            end else if (c == stk_pkg::CH_DOT && mode_ff == stk_pkg::M_INT) begin
               mode_in = stk_pkg::M_INT_DOT;
            end else begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_NUMBER, lstart_ff, llen_ff,
                                                line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         stk_pkg::M_INT_DOT: begin
            if (stk_pkg::is_digit(c)) begin
               llen_in = stk_pkg::sat_add(llen_ff, 16'd2, 16'hFFFF);
               mode_in = stk_pkg::M_FRAC;
            end else begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_NUMBER, lstart_ff, llen_ff,
                                                line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_DOT,
                                                stk_pkg::sat_add(lstart_ff, llen_ff, OFFSET_CAP),
                                                16'd1, line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         stk_pkg::M_STRING: begin
            if (c == stk_pkg::CH_NUL) begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_ERROR, lstart_ff, llen_ff,
                                                line_ff, stk_pkg::E_UNTERMINATED);
               n = n + 2'd1;
               rescan = 1'b1;
            end else begin
               llen_in = stk_pkg::sat_add(llen_ff, 16'd1, 16'hFFFF);
               if (c == stk_pkg::CH_QUOTE) begin
                  bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_STRING, lstart_ff, llen_in,
                                                   line_ff, stk_pkg::E_NONE);
                  n = n + 2'd1;
                  mode_in = stk_pkg::M_IDLE;
               end else if (c == stk_pkg::CH_NL) begin
                  line_in = stk_pkg::sat_add(line_ff, 16'd1, 16'hFFFF);
               end
            end
         end
         stk_pkg::M_COMMENT: begin
            rescan = (c == stk_pkg::CH_NL) || (c == stk_pkg::CH_NUL);
         end
         stk_pkg::M_OPERATOR: begin
            if (held_ff == stk_pkg::CH_SLASH) begin
               if (c == stk_pkg::CH_SLASH) begin
                  mode_in = stk_pkg::M_COMMENT;
               end else begin
                  bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_SLASH, lstart_ff, 16'd1,
                                                   line_ff, stk_pkg::E_NONE);
                  n = n + 2'd1;
                  rescan = 1'b1;
               end
            end else if (c == stk_pkg::CH_EQ) begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::operator_kind(held_ff, 1'b1),
                                                lstart_ff, 16'd2, line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               mode_in = stk_pkg::M_IDLE;
            end else begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::operator_kind(held_ff, 1'b0),
                                                lstart_ff, 16'd1, line_ff, stk_pkg::E_NONE);
               n = n + 2'd1;
               rescan = 1'b1;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // Scan the byte afresh as the first byte of a new lexeme.
      if (rescan) begin
         mode_in = stk_pkg::M_IDLE;
         if (c == stk_pkg::CH_NUL) begin
            bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_END, roff_ff, 16'd0, line_ff,
                                             stk_pkg::E_NONE);
            n = n + 2'd1;
         end else if (c == stk_pkg::CH_SPACE || c == stk_pkg::CH_CR || c == stk_pkg::CH_TAB) begin
            mode_in = stk_pkg::M_IDLE;
         end else if (c == stk_pkg::CH_NL) begin
            line_in = stk_pkg::sat_add(line_ff, 16'd1, 16'hFFFF);
         end else begin
            lstart_in = roff_ff;
            llen_in = 16'd1;
            sk = stk_pkg::single_kind(c);
            if (stk_pkg::is_letter(c)) begin
               mode_in = stk_pkg::M_WORD;
               cand_in = stk_pkg::keep_mask(3'd0, c);
               wlen_in = 3'd1;
            end else if (stk_pkg::is_digit(c)) begin
               mode_in = stk_pkg::M_INT;
            end else if (c == stk_pkg::CH_QUOTE) begin
               mode_in = stk_pkg::M_STRING;
            end else if (c == stk_pkg::CH_BANG || c == stk_pkg::CH_EQ || c == stk_pkg::CH_LT ||
                         c == stk_pkg::CH_GT || c == stk_pkg::CH_SLASH) begin
               mode_in = stk_pkg::M_OPERATOR;
               held_in = c;
            end else if (sk[6]) begin
               bundle.toks[n] = stk_pkg::mk_tok(sk[5:0], roff_ff, 16'd1, line_ff,
                                                stk_pkg::E_NONE);
               n = n + 2'd1;
            end else begin
               bundle.toks[n] = stk_pkg::mk_tok(stk_pkg::K_ERROR, roff_ff, 16'd1, line_ff,
                                                stk_pkg::E_UNEXPECTED);
               n = n + 2'd1;
            end
         end
      end

      // End of source restarts every counter for the next source.
      if (c == stk_pkg::CH_NUL) begin
         mode_in = stk_pkg::M_IDLE;
         roff_in = '0;
         lstart_in = '0;
         line_in = 16'd1;
         cand_in = '0;
         wlen_in = '0;
         held_in = '0;
         llen_in = '0;
      end else begin
         roff_in = stk_pkg::sat_add(roff_ff, 16'd1, OFFSET_CAP);
      end

      bundle.count = n;
   end

   assign bundle_push = byte_valid && (bundle.count != 2'd0);

endmodule

[src/stk_queue.sv]
// Short queue of token bundles between the front scanner and the drainer.
// Depends on stk_pkg for the bundle type and the queue depth.
module stk_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stk_pkg::bundle_type wdata,
   output logic                full,
   input  logic                pop,
   output stk_pkg::bundle_type rdata,
   output logic                empty
);

   stk_pkg::bundle_type store_ff [stk_pkg::QUEUE_DEPTH];
   logic [stk_pkg::QUEUE_AW-1:0] wptr_ff, rptr_ff;
   logic [stk_pkg::QUEUE_AW:0]   fill_ff;

   assign full  = (fill_ff == (stk_pkg::QUEUE_AW + 1)'(stk_pkg::QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign rdata = store_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

[src/stk_back.sv]
// Token drainer: holds one bundle and hands its tokens out one per pop.
// Depends on stk_pkg for the bundle and token types.
module stk_back (
   input  logic                clock,
   input  logic                reset,
   input  stk_pkg::bundle_type q_data,
   input  logic                q_empty,
   output logic                q_pop,
   output stk_pkg::tok_type    tok,
   output logic                last,
   output logic                out_empty,
   input  logic                out_pop
);

   stk_pkg::bundle_type cur_ff;
   logic                valid_ff;
   logic [1:0]          idx_ff;
   logic                take;

   assign tok       = cur_ff.toks[idx_ff];
   assign last      = (idx_ff == cur_ff.count - 2'd1);
   assign out_empty = !valid_ff;
   assign take      = !valid_ff || (out_pop && last);
   assign q_pop     = take && !q_empty;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (take) begin
         valid_ff <= !q_empty;
         idx_ff   <= '0;
      end else if (out_pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

[src/script_tokenizer_core.sv]
// Top level of the script tokenizer: front scanner, bundle queue and token drainer.
// Depends on stk_pkg, stk_front, stk_queue and stk_back.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_push/req_full  req_source_byte
//   rsp_      out        rsp_empty/rsp_pop  rsp_token_kind .. rsp_last_of_run
//
// The scanner takes one source byte per cycle while req_full is low; the byte's tokens
// (zero to three) are written as one bundle into a four-entry queue in the same edge.
// The drainer hands out one token per cycle while rsp_pop is high and tokens are waiting,
// and the queue absorbs the burst of a byte that ends three tokens.
// Reset is synchronous and clears the scanner state, queue pointers and drainer.
// req_full rises only when the queue is full; a stalled output never blocks
// the scanner until the queue fills.
module script_tokenizer_core #(
   parameter int MAX_SOURCE_BYTES = stk_pkg::MAX_SOURCE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_token_line,
   output logic [1:0]  rsp_error_kind,
   output logic        rsp_last_of_run
);

   // Bundle path from the scanner into the queue.
   logic                b_push;
   stk_pkg::bundle_type b_data;
   logic                q_full;
   // Bundle path from the queue into the drainer.
   stk_pkg::bundle_type q_data;
   logic                q_empty;
   logic                q_pop;
   stk_pkg::tok_type    tok;

   // A request is taken whenever the queue has room for its bundle.
   assign req_full = q_full;

   stk_front #(
      .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_push && !q_full),
      .source_byte (req_source_byte),
      .bundle_push (b_push),
      .bundle      (b_data)
   );

   stk_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (b_push),
      .wdata (b_data),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   stk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .tok       (tok),
      .last      (rsp_last_of_run),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop)
   );

   assign rsp_token_kind   = tok.kind;
   assign rsp_token_start  = tok.start;
   assign rsp_token_length = tok.length;
   assign rsp_token_line   = tok.line;
   assign rsp_error_kind   = tok.err;

`ifndef SYNTHESIS
   // A bundle is never written into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      b_push |-> !q_full) else $error("bundle written into full queue");

   // A token that is not the last of its byte is always followed by another.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_of_run) |=> !rsp_empty)
      else $error("token run broken");

   // Every shown token carries a defined kind.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_token_kind <= stk_pkg::K_END))
      else $error("token kind out of range");
`endif

endmodule

[tb/tb_script_tokenizer_core.sv]
// Self-checking testbench for script_tokenizer_core: random and directed source text,
// each token checked against a scanner model kept in the testbench.
// Depends on stk_pkg (mode type, kind and error codes, keyword table) and the core.
module tb_script_tokenizer_core;

   localparam int OFFSET_CAP = 65535;
   localparam int CYCLE_LIMIT = 900000;
   localparam int LONG_STRING_BYTES = 5;
   localparam int HOLD_OFF_CYCLES = 120;

   // One token as the core should hand it out.
   typedef struct {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [1:0]  err;
      logic        last;
   } token_type;

   // A directed request; when checked is set, the first token of that byte is
   // also compared with the values typed into the row.
   typedef struct {
      logic [7:0]  text;
      bit          checked;
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [1:0]  err;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_source_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_token_line;
   logic [1:0]  rsp_error_kind;
   logic        rsp_last_of_run;

   script_tokenizer_core dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_source_byte(req_source_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_token_kind(rsp_token_kind), .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length), .rsp_token_line(rsp_token_line),
      .rsp_error_kind(rsp_error_kind), .rsp_last_of_run(rsp_last_of_run)
   );

   // Tokens still owed by the core, oldest first.
   token_type pending_tokens[$];
   // Tokens caused by the byte that was scanned last.
   token_type byte_tokens[$];

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   // High while the receiver holds off completely.
   bit hold_rx = 1'b0;

   // Scanner model state.
   stk_pkg::mode_type sc_mode;
   logic [15:0] sc_lex_start;
   logic [15:0] sc_offset;
   logic [15:0] sc_line;
   logic [16:0] sc_candidates;
   logic [2:0]  sc_word_len;
   logic [7:0]  sc_held;
   logic [15:0] sc_lex_len;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is bounded by a cycle count so that a hung handshake cannot stall it.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_script_tokenizer_core: FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] add_capped(input logic [15:0] a, input int b,
                                              input int cap);
      int s;
      s = int'(a) + b;
      return (s > cap) ? 16'(cap) : 16'(s);
   endfunction

   function automatic bit letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic add_token(input logic [5:0] kind, input logic [15:0] start,
                            input logic [15:0] length, input logic [1:0] err);
      token_type t;
      t.kind = kind;
      t.start = start;
      t.length = length;
      t.line = sc_line;
      t.err = err;
      t.last = 1'b0;
      byte_tokens.push_back(t);
   endtask

   // Keep the keywords whose next letter matches, then step the word length.
   task automatic narrow_keywords(input logic [7:0] c);
      logic [16:0] keep;
      keep = '0;
      if (sc_word_len < 3'd6) begin
         for (int i = 0; i < stk_pkg::NUM_KEYWORDS; i++) begin
            keep[i] = (stk_pkg::KW_CHARS[i][sc_word_len] == c);
         end
      end
      sc_candidates &= keep;
      if (sc_word_len < 3'd7) sc_word_len = sc_word_len + 3'd1;
   endtask

   task automatic finish_word();
      logic [5:0] kind;
      kind = stk_pkg::K_IDENT;
      for (int i = 0; i < stk_pkg::NUM_KEYWORDS; i++) begin
         if (kind == stk_pkg::K_IDENT && sc_candidates[i] &&
             stk_pkg::KW_LEN[i] == sc_word_len) begin
            kind = stk_pkg::K_KEYWORD0 + 6'(i);
         end
      end
      add_token(kind, sc_lex_start, sc_lex_len, stk_pkg::E_NONE);
   endtask

   // Scan a byte from the state between tokens.
   task automatic scan_fresh(input logic [7:0] c);
      sc_mode = stk_pkg::M_IDLE;
      if (c == stk_pkg::CH_NUL) begin
         add_token(stk_pkg::K_END, sc_offset, 16'd0, stk_pkg::E_NONE);
      end else if (c == stk_pkg::CH_NL) begin
         sc_line = add_capped(sc_line, 1, 65535);
      end else if (c != stk_pkg::CH_SPACE && c != stk_pkg::CH_CR && c != stk_pkg::CH_TAB) begin
         sc_lex_start = sc_offset;
         sc_lex_len = 16'd1;
         if (letter(c)) begin
            sc_mode = stk_pkg::M_WORD;
            sc_candidates = '1;
            sc_word_len = 3'd0;
            narrow_keywords(c);
         end else if (digit(c)) begin
            sc_mode = stk_pkg::M_INT;
         end else if (c == stk_pkg::CH_QUOTE) begin
            sc_mode = stk_pkg::M_STRING;
         end else if (c == stk_pkg::CH_BANG || c == stk_pkg::CH_EQ || c == stk_pkg::CH_LT ||
                      c == stk_pkg::CH_GT || c == stk_pkg::CH_SLASH) begin
            sc_mode = stk_pkg::M_OPERATOR;
            sc_held = c;
         end else begin
            case (c)
               "(": add_token(6'd0, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               ")": add_token(6'd1, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "{": add_token(6'd2, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "}": add_token(6'd3, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               ",": add_token(6'd4, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               ".": add_token(stk_pkg::K_DOT, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               ";": add_token(6'd6, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               ":": add_token(6'd7, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "?": add_token(6'd8, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "-": add_token(6'd9, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "+": add_token(6'd10, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               "*": add_token(6'd12, sc_lex_start, 16'd1, stk_pkg::E_NONE);
               default: add_token(stk_pkg::K_ERROR, sc_lex_start, 16'd1, stk_pkg::E_UNEXPECTED);
            endcase
         end
      end
   endtask

   function automatic logic [5:0] relational_kind(input logic [7:0] c, input bit doubled);
      case (c)
         stk_pkg::CH_BANG: return doubled ? 6'd14 : 6'd13;
         stk_pkg::CH_EQ:   return doubled ? 6'd16 : 6'd15;
         stk_pkg::CH_GT:   return doubled ? 6'd18 : 6'd17;
         default:          return doubled ? 6'd20 : 6'd19;
      endcase
   endfunction

   task automatic clear_scanner();
      sc_mode = stk_pkg::M_IDLE;
      sc_lex_start = '0;
      sc_offset = '0;
      sc_line = 16'd1;
      sc_candidates = '0;
      sc_word_len = '0;
      sc_held = '0;
      sc_lex_len = '0;
   endtask

   // Advance the model by one accepted byte and queue the tokens it ends.
   task automatic scan_byte(input logic [7:0] c);
      bit again;
      again = 1'b0;
      byte_tokens.delete();
      case (sc_mode)
         stk_pkg::M_WORD: begin
            if (letter(c) || digit(c) || c == stk_pkg::CH_UNDER) begin
               sc_lex_len = add_capped(sc_lex_len, 1, 65535);
               narrow_keywords(c);
            end else begin
               finish_word();
               again = 1'b1;
            end
         end
         stk_pkg::M_INT: begin
            if (digit(c)) sc_lex_len = add_capped(sc_lex_len, 1, 65535);
            else if (c == stk_pkg::CH_DOT) sc_mode = stk_pkg::M_INT_DOT;
            else begin
               add_token(stk_pkg::K_NUMBER, sc_lex_start, sc_lex_len, stk_pkg::E_NONE);
               again = 1'b1;
            end
         end
         stk_pkg::M_INT_DOT: begin
            if (digit(c)) begin
               sc_lex_len = add_capped(sc_lex_len, 2, 65535);
               sc_mode = stk_pkg::M_FRAC;
            end else begin
               // Digits and a dot not followed by a digit: number, then dot.
               add_token(stk_pkg::K_NUMBER, sc_lex_start, sc_lex_len, stk_pkg::E_NONE);
               add_token(stk_pkg::K_DOT,
                         add_capped(sc_lex_start, int'(sc_lex_len), OFFSET_CAP),
                         16'd1, stk_pkg::E_NONE);
               again = 1'b1;
            end
         end
         stk_pkg::M_FRAC: begin
            if (digit(c)) sc_lex_len = add_capped(sc_lex_len, 1, 65535);
            else begin
               add_token(stk_pkg::K_NUMBER, sc_lex_start, sc_lex_len, stk_pkg::E_NONE);
               again = 1'b1;
            end
         end
         stk_pkg::M_STRING: begin
            if (c == stk_pkg::CH_NUL) begin
               add_token(stk_pkg::K_ERROR, sc_lex_start, sc_lex_len, stk_pkg::E_UNTERMINATED);
               again = 1'b1;
            end else begin
               sc_lex_len = add_capped(sc_lex_len, 1, 65535);
               if (c == stk_pkg::CH_QUOTE) begin
                  add_token(stk_pkg::K_STRING, sc_lex_start, sc_lex_len, stk_pkg::E_NONE);
                  sc_mode = stk_pkg::M_IDLE;
               end else if (c == stk_pkg::CH_NL) begin
                  sc_line = add_capped(sc_line, 1, 65535);
               end
            end
         end
         stk_pkg::M_COMMENT: begin
            if (c == stk_pkg::CH_NL || c == stk_pkg::CH_NUL) again = 1'b1;
         end
         stk_pkg::M_OPERATOR: begin
            if (sc_held == stk_pkg::CH_SLASH) begin
               if (c == stk_pkg::CH_SLASH) sc_mode = stk_pkg::M_COMMENT;
               else begin
                  add_token(stk_pkg::K_SLASH, sc_lex_start, 16'd1, stk_pkg::E_NONE);
                  again = 1'b1;
               end
            end else if (c == stk_pkg::CH_EQ) begin
               add_token(relational_kind(sc_held, 1'b1), sc_lex_start, 16'd2, stk_pkg::E_NONE);
               sc_mode = stk_pkg::M_IDLE;
            end else begin
               add_token(relational_kind(sc_held, 1'b0), sc_lex_start, 16'd1, stk_pkg::E_NONE);
               again = 1'b1;
            end
         end
         default: again = 1'b1;
      endcase
      if (again) scan_fresh(c);
      if (c == stk_pkg::CH_NUL) clear_scanner();
      else sc_offset = add_capped(sc_offset, 1, OFFSET_CAP);
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s expected %0d, got %0d",
                  cycle_count, field, want, got);
      end
   endtask

   // Offer one byte and wait until the core takes it; the model advances on
   // the edge that accepts the request.
   task automatic offer_byte(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_source_byte <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      scan_byte(c);
   endtask

   // Result side: compare every popped token, then pick the next pop.
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_tokens.size() == 0) begin
               report_mismatch("token with none outstanding, kind", -1, rsp_token_kind);
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_token_kind !== want.kind) report_mismatch("kind", want.kind, rsp_token_kind);
               if (rsp_token_start !== want.start)
                  report_mismatch("start", want.start, rsp_token_start);
               if (rsp_token_length !== want.length)
                  report_mismatch("length", want.length, rsp_token_length);
               if (rsp_token_line !== want.line) report_mismatch("line", want.line, rsp_token_line);
               if (rsp_error_kind !== want.err) report_mismatch("error", want.err, rsp_error_kind);
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last", want.last, rsp_last_of_run);
            end
         end
         if (hold_rx) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Build one random lexeme, mostly well formed, into the byte stream.
   task automatic make_lexeme(ref logic [7:0] text[$]);
      string punct;
      string rel;
      int pick;
      int n;
      punct = "(){},.;:?-+*";
      rel = "!=<>/";
      pick = $urandom_range(99);
      if (pick < 14) begin
         n = $urandom_range(stk_pkg::NUM_KEYWORDS - 1);
         for (int i = 0; i < stk_pkg::KW_LEN[n]; i++) text.push_back(stk_pkg::KW_CHARS[n][i]);
      end else if (pick < 28) begin
         text.push_back(($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25)));
         n = $urandom_range(9);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: text.push_back("0" + 8'($urandom_range(9)));
               1: text.push_back(stk_pkg::CH_UNDER);
               default: text.push_back("a" + 8'($urandom_range(25)));
            endcase
         end
      end else if (pick < 42) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) text.push_back("0" + 8'($urandom_range(9)));
         if ($urandom_range(1)) begin
            text.push_back(stk_pkg::CH_DOT);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) text.push_back("0" + 8'($urandom_range(9)));
         end
      end else if (pick < 50) begin
         text.push_back(stk_pkg::CH_QUOTE);
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) begin
            text.push_back($urandom_range(4) == 0 ? stk_pkg::CH_NL : 8'($urandom_range(35, 126)));
         end
         if ($urandom_range(7) != 0) text.push_back(stk_pkg::CH_QUOTE);
      end else if (pick < 64) begin
         text.push_back(punct[$urandom_range(punct.len() - 1)]);
      end else if (pick < 78) begin
         text.push_back(rel[$urandom_range(rel.len() - 1)]);
         if ($urandom_range(1)) text.push_back(stk_pkg::CH_EQ);
      end else if (pick < 83) begin
         text.push_back(stk_pkg::CH_SLASH);
         text.push_back(stk_pkg::CH_SLASH);
         n = $urandom_range(5);
         for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(1, 255)));
         text.push_back(stk_pkg::CH_NL);
      end else if (pick < 90) begin
         case ($urandom_range(3))
            0: text.push_back(stk_pkg::CH_TAB);
            1: text.push_back(stk_pkg::CH_CR);
            2: text.push_back(stk_pkg::CH_NL);
            default: text.push_back(stk_pkg::CH_SPACE);
         endcase
      end else if (pick < 97) begin
         text.push_back(8'($urandom_range(255)));
      end else begin
         text.push_back(stk_pkg::CH_NUL);
      end
      // Tokens often touch, so that one byte can end several of them.
      if ($urandom_range(2) == 0) text.push_back(stk_pkg::CH_SPACE);
   endtask

   // Offer about count random bytes.
   task automatic random_run(input int count);
      logic [7:0] text[$];
      while (text.size() < count) make_lexeme(text);
      foreach (text[i]) offer_byte(text[i]);
   endtask

   // Stop offering and wait until every outstanding token has been popped.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   directed_row_type directed_rows[$];

   task automatic add_row(input logic [7:0] c, input bit checked, input logic [5:0] kind,
                          input int start, input int length, input logic [1:0] err);
      directed_row_type r;
      r.text = c;
      r.checked = checked;
      r.kind = kind;
      r.start = 16'(start);
      r.length = 16'(length);
      r.err = err;
      directed_rows.push_back(r);
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_source_byte = '0;
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed text: extreme and special bytes, a keyword, number then dot,
      // a doubled operator, a comment and an unterminated string.
      add_row("(", 1, 6'd0, 0, 1, stk_pkg::E_NONE);
      add_row(8'h80, 1, stk_pkg::K_ERROR, 1, 1, stk_pkg::E_UNEXPECTED);
      add_row(stk_pkg::CH_UNDER, 1, stk_pkg::K_ERROR, 2, 1, stk_pkg::E_UNEXPECTED);
      add_row(8'hFF, 1, stk_pkg::K_ERROR, 3, 1, stk_pkg::E_UNEXPECTED);
      add_row("w", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("h", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("i", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("l", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("e", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_SPACE, 1, stk_pkg::K_KEYWORD0 + 6'd16, 4, 5, stk_pkg::E_NONE);
      add_row("1", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_DOT, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(";", 1, stk_pkg::K_NUMBER, 10, 1, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_BANG, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_EQ, 1, 6'd14, 13, 2, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_SLASH, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_SLASH, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("x", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_NL, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_QUOTE, 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row("a", 0, 0, 0, 0, stk_pkg::E_NONE);
      add_row(stk_pkg::CH_NUL, 1, stk_pkg::K_ERROR, 19, 2, stk_pkg::E_UNTERMINATED);
      add_row(stk_pkg::CH_NUL, 1, stk_pkg::K_END, 0, 0, stk_pkg::E_NONE);

      send_idle_pct = 28;
      recv_idle_pct = 87;
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].text);
         if (directed_rows[i].checked) begin
            if (byte_tokens.size() == 0) begin
               report_mismatch("directed row tokens", 1, 0);
            end else begin
               if (byte_tokens[0].kind !== directed_rows[i].kind)
                  report_mismatch("directed kind", directed_rows[i].kind, byte_tokens[0].kind);
               if (byte_tokens[0].start !== directed_rows[i].start)
                  report_mismatch("directed start", directed_rows[i].start, byte_tokens[0].start);
               if (byte_tokens[0].length !== directed_rows[i].length)
                  report_mismatch("directed length", directed_rows[i].length,
                                  byte_tokens[0].length);
               if (byte_tokens[0].err !== directed_rows[i].err)
                  report_mismatch("directed error", directed_rows[i].err, byte_tokens[0].err);
            end
         end
      end

      // Phase one: the receiver mostly idles, and once holds off entirely so
      // the queue fills and the core pushes back on requests.
      random_run(40);
      fork
         begin
            hold_rx <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_rx <= 1'b0;
         end
      join_none
      random_run(80);

      // Phase two: the sender mostly idles, and once pauses until every
      // outstanding token has been popped.
      send_idle_pct = 87;
      recv_idle_pct = 28;
      random_run(60);
      wait_drained();
      random_run(60);

      // Phase three: no idling; a string holding several newlines is closed
      // and followed by an operator and the end of source.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_run(100);
      offer_byte(stk_pkg::CH_NUL);
      offer_byte(stk_pkg::CH_QUOTE);
      for (int i = 0; i < LONG_STRING_BYTES; i++) offer_byte(stk_pkg::CH_NL);
      offer_byte(stk_pkg::CH_QUOTE);
      offer_byte("+");
      offer_byte(stk_pkg::CH_NUL);
      req_push <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_tokens.size() == 0) begin
         $display("tb_script_tokenizer_core: PASS");
      end else begin
         $display("tb_script_tokenizer_core: FAIL");
      end
      $finish;
   end

endmodule
